>>> rtl/access_card_table_top_defines.svh
// Assertion macros for the access card table block.
// Used by access_card_table_top; expects clk and rst_n in scope.
`ifndef ACCESS_CARD_TABLE_TOP_DEFINES_SVH
`define ACCESS_CARD_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ACT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("access_card_table: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ACT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("access_card_table: next-cycle check failed");

`endif

>>> rtl/act_pkg.sv
// Shared types and constants for the access card table block.
// No dependencies; used by act_ctrl, act_dp and access_card_table_top.
package act_pkg;

  localparam int ID_W              = 40;
  localparam int TABLE_DEPTH_DEF   = 16;
  localparam logic [ID_W-1:0] MASTER_RESET = 40'h53_0835_147A;

  // Item commands
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_MASTER    = 4'd0;
  localparam logic [3:0] ST_MEMBER    = 4'd1;
  localparam logic [3:0] ST_UNKNOWN   = 4'd2;
  localparam logic [3:0] ST_ADDED     = 4'd3;
  localparam logic [3:0] ST_DUPLICATE = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_REMOVED   = 4'd6;
  localparam logic [3:0] ST_NOTFOUND  = 4'd7;
  localparam logic [3:0] ST_EMPTY     = 4'd8;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] card_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       unlock;
    logic [3:0] match_index;
    logic [4:0] member_count;
  } out_item_t;

  // Source of the reported slot index
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_HIT,
    IDX_COUNT
  } idx_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       scan_en;
    logic       start_shift;
    logic       shift_en;
    logic       append;
    logic       cnt_dec;
    logic       set_res;
    logic [3:0] res_status;
    idx_sel_t   idx_sel;
    logic       load_out;
  } act_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] item_cmd;
    logic       master_hit;
    logic       full;
    logic       empty;
    logic       hit;
    logic       pipe_done;
    logic       out_free;
  } act_sts_t;

endpackage

>>> rtl/act_ctrl.sv
// Sequencer for the access card table: decide, scan, shift, report.
// Depends on act_pkg; drives act_dp through act_cmd_t.
module act_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  act_pkg::act_sts_t sts,
  output act_pkg::act_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.idx_sel    = act_pkg::IDX_ZERO;
    cmd.res_status = act_pkg::ST_UNKNOWN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.item_cmd == act_pkg::CMD_LOOKUP && sts.master_hit) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = act_pkg::ST_MASTER;
          state_nxt      = S_RESULT;
        end else if (sts.item_cmd == act_pkg::CMD_ADD && sts.full) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = act_pkg::ST_FULL;
          state_nxt      = S_RESULT;
        end else if (sts.item_cmd == act_pkg::CMD_REMOVE && sts.empty) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = act_pkg::ST_EMPTY;
          state_nxt      = S_RESULT;
        end else if (sts.item_cmd != act_pkg::CMD_LOOKUP &&
                     sts.item_cmd != act_pkg::CMD_ADD &&
                     sts.item_cmd != act_pkg::CMD_REMOVE) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = act_pkg::ST_UNKNOWN;
          state_nxt      = S_RESULT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.hit) begin
          cmd.set_res = 1'b1;
          cmd.idx_sel = act_pkg::IDX_HIT;
          state_nxt   = S_RESULT;
          if (sts.item_cmd == act_pkg::CMD_LOOKUP) begin
            cmd.res_status = act_pkg::ST_MEMBER;
          end else if (sts.item_cmd == act_pkg::CMD_ADD) begin
            cmd.res_status = act_pkg::ST_DUPLICATE;
          end else begin
            cmd.res_status  = act_pkg::ST_REMOVED;
            cmd.start_shift = 1'b1;
            state_nxt       = S_SHIFT;
          end
        end else if (sts.pipe_done) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_RESULT;
          if (sts.item_cmd == act_pkg::CMD_LOOKUP) begin
            cmd.res_status = act_pkg::ST_UNKNOWN;
          end else if (sts.item_cmd == act_pkg::CMD_ADD) begin
            cmd.res_status = act_pkg::ST_ADDED;
            cmd.idx_sel    = act_pkg::IDX_COUNT;
            cmd.append     = 1'b1;
          end else begin
            cmd.res_status = act_pkg::ST_NOTFOUND;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        if (sts.pipe_done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/act_dp.sv
// Datapath for the access card table: card memory, master ID, member count,
// scan/shift read pipeline and the result register. Depends on act_pkg.
module act_dp #(
  parameter int TABLE_DEPTH = act_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  act_pkg::in_item_t         in_item,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [act_pkg::ID_W-1:0]  cfg_data,
  input  logic                      out_ready,
  output logic                      out_valid,
  output act_pkg::out_item_t        out_item,
  input  act_pkg::act_cmd_t         cmd,
  output act_pkg::act_sts_t         sts
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [act_pkg::ID_W-1:0] card_mem [TABLE_DEPTH];

  logic [act_pkg::ID_W-1:0] master_r;
  logic [1:0]               item_cmd_r;
  logic [act_pkg::ID_W-1:0] item_id_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         rk_r;
  logic                     rv_r, rv_nxt;
  logic [act_pkg::ID_W-1:0] rd_data_r;
  logic [3:0]               res_status_r;
  logic [CNT_W-1:0]         res_idx_r, res_idx_nxt;
  logic                     out_valid_r;
  act_pkg::out_item_t       out_item_r;

  logic                     issue;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [act_pkg::ID_W-1:0] wr_data;
  logic [CNT_W-1:0]         shift_dst;

  // One read per cycle during a scan or shift while the pointer is below the member count
  assign issue     = (cmd.scan_en || cmd.shift_en) && (ptr_r < count_r);
  assign shift_dst = CNT_W'(rk_r - CNT_W'(1));

  always_comb begin
    ptr_nxt = ptr_r;
    rv_nxt  = issue;
    if (cmd.load_item) begin
      ptr_nxt = '0;
    end else if (cmd.start_shift) begin
      // entries above the hit slot move down; drop the read in flight
      ptr_nxt = CNT_W'(rk_r + CNT_W'(1));
      rv_nxt  = 1'b0;
    end else if (issue) begin
      ptr_nxt = CNT_W'(ptr_r + CNT_W'(1));
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = item_id_r;
    if (cmd.append) begin
      wr_en = 1'b1;
    end else if (cmd.shift_en && rv_r) begin
      wr_en   = 1'b1;
      wr_addr = shift_dst[IDX_W-1:0];
      wr_data = rd_data_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.append) begin
      count_nxt = CNT_W'(count_r + CNT_W'(1));
    end else if (cmd.cnt_dec) begin
      count_nxt = CNT_W'(count_r - CNT_W'(1));
    end
  end

  always_comb begin
    unique case (cmd.idx_sel)
      act_pkg::IDX_HIT:   res_idx_nxt = rk_r;
      act_pkg::IDX_COUNT: res_idx_nxt = count_r;
      default:            res_idx_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      card_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= card_mem[ptr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= act_pkg::MASTER_RESET;
      count_r     <= '0;
      ptr_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        master_r <= cfg_data;
      end
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      rv_r    <= rv_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r <= in_item.command;
      item_id_r  <= in_item.card_id;
    end
    rk_r <= ptr_r;
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_idx_r    <= res_idx_nxt;
    end
    if (cmd.load_out) begin
      out_item_r.status       <= res_status_r;
      out_item_r.unlock       <= (res_status_r == act_pkg::ST_MASTER) ||
                                 (res_status_r == act_pkg::ST_MEMBER);
      out_item_r.match_index  <= 4'(res_idx_r);
      out_item_r.member_count <= 5'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign sts.item_cmd   = item_cmd_r;
  assign sts.master_hit = (item_id_r == master_r);
  assign sts.full       = (count_r >= CNT_W'(TABLE_DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.hit        = rv_r && (rd_data_r == item_id_r);
  assign sts.pipe_done  = (ptr_r >= count_r) && !rv_r;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

>>> rtl/access_card_table_top.sv
// Access card table top level: whitelist of 40-bit card IDs with master ID.
// Depends on act_pkg, act_ctrl, act_dp and access_card_table_top_defines.svh.
//
// One item at a time, one result per item. A lookup or add reads the stored
// members through the single read port of the card memory, one entry per
// cycle. A match ends the scan early; master, full, empty and unused commands
// skip the scan. A remove that hits then moves every entry above the removed
// slot down by one, one entry per cycle through the same port. The result
// sits in an output register, so the next item is taken while a result waits.
// The memory is not cleared at reset; only slots below the member count are
// read.
`include "access_card_table_top_defines.svh"

module access_card_table_top #(
  parameter int TABLE_DEPTH = act_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  act_pkg::in_item_t        in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output act_pkg::out_item_t       out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [act_pkg::ID_W-1:0] cfg_data
);

  act_pkg::act_cmd_t cmd;
  act_pkg::act_sts_t sts;

  assign cfg_ready = 1'b1;

  act_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  act_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Never append into a full table
  `ACT_ASSERT_IMP(a_no_append_full, cmd.append, !sts.full)
  // Result register only loads when its previous beat is gone
  `ACT_ASSERT_IMP(a_load_out_free, cmd.load_out, sts.out_free)
  // One item in flight: no second beat right after an accept
  `ACT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // Unlock only on master or member status
  `ACT_ASSERT_IMP(a_unlock_status, out_valid && out_item.unlock,
    out_item.status == act_pkg::ST_MASTER || out_item.status == act_pkg::ST_MEMBER)

endmodule

>>> verif/card_table_check.sv
// Result checker for the access card table: keeps a shadow roster and master ID,
// works out the verdict of every accepted item and compares the result beats.
// Depends on act_pkg; instantiated next to the block by tb_top.
module card_table_check #(
  parameter int TABLE_DEPTH = act_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  act_pkg::in_item_t        in_item,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  act_pkg::out_item_t       out_item,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [act_pkg::ID_W-1:0] cfg_data,
  output int                       mismatch_count,
  output int                       verdicts_owed
);
  import act_pkg::*;

  logic [ID_W-1:0] roster [TABLE_DEPTH];
  int unsigned     roster_cnt;
  logic [ID_W-1:0] master_id;
  out_item_t       verdict_q [$];
  int              fails = 0;

  assign mismatch_count = fails;

  // First stored slot holding id, -1 when absent
  function automatic int find_member(logic [ID_W-1:0] id);
    for (int k = 0; k < int'(roster_cnt); k++) begin
      if (roster[k] == id) return k;
    end
    return -1;
  endfunction

  // Verdict of one item; updates the shadow roster like the block should
  function automatic out_item_t classify_card(in_item_t it);
    out_item_t r;
    int slot;
    r.status      = ST_UNKNOWN;
    r.unlock      = 1'b0;
    r.match_index = '0;
    case (it.command)
      CMD_LOOKUP: begin
        // master wins even if the same ID is stored as a member
        if (it.card_id == master_id) begin
          r.status = ST_MASTER;
          r.unlock = 1'b1;
        end else begin
          slot = find_member(it.card_id);
          if (slot >= 0) begin
            r.status      = ST_MEMBER;
            r.unlock      = 1'b1;
            r.match_index = 4'(slot);
          end
        end
      end
      CMD_ADD: begin
        if (roster_cnt >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = find_member(it.card_id);
          if (slot >= 0) begin
            r.status      = ST_DUPLICATE;
            r.match_index = 4'(slot);
          end else begin
            roster[roster_cnt] = it.card_id;
            r.match_index      = 4'(roster_cnt);
            roster_cnt++;
            r.status = ST_ADDED;
          end
        end
      end
      CMD_REMOVE: begin
        if (roster_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = find_member(it.card_id);
          if (slot < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int k = slot; k + 1 < int'(roster_cnt); k++) roster[k] = roster[k+1];
            roster[roster_cnt-1] = '0;
            roster_cnt--;
            r.status      = ST_REMOVED;
            r.match_index = 4'(slot);
          end
        end
      end
      default: ;
    endcase
    r.member_count = 5'(roster_cnt);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      roster_cnt = 0;
      master_id  = MASTER_RESET;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) master_id = cfg_data;
      if (in_valid && in_ready) verdict_q.push_back(classify_card(in_item));
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got status %0d", $time,
                   out_item.status);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_item.status));
          check_field("unlock", 8'(want.unlock), 8'(out_item.unlock));
          check_field("match_index", 8'(want.match_index), 8'(out_item.match_index));
          check_field("member_count", 8'(want.member_count), 8'(out_item.member_count));
        end
      end
    end
    verdicts_owed <= verdict_q.size();
  end

  final begin
    // nothing printed here; leftovers are caught by the top through verdicts_owed
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for access_card_table_top: drives items, master ID writes and
// result back-pressure, and gives the verdict. Depends on act_pkg and card_table_check.
module tb_top;
  import act_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 120;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 60;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_item;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data = '0;

  int mismatch_count;
  int verdicts_owed;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  always #10 clk = ~clk;

  access_card_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  card_table_check card_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .verdicts_owed  (verdicts_owed)
  );

  // Watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls per beat while rx_idle is set, plus one long hold on request
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [ID_W-1:0] rand_id();
    return {8'($urandom()), 32'($urandom())};
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [ID_W-1:0] id);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_item.command <= cmd;
    in_item.card_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
  endtask

  task automatic write_master(logic [ID_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    logic [ID_W-1:0] master;
    logic [1:0]      cmd;
    logic [ID_W-1:0] id;
    int              add_w;
    int              rem_w;
    int              r;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, master-first lookup, duplicate, shift on remove, full
    send_item(CMD_LOOKUP, MASTER_RESET);
    send_item(CMD_LOOKUP, '0);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_UNUSED, '1);
    send_item(CMD_ADD, '0);
    send_item(CMD_ADD, '1);
    send_item(CMD_ADD, MASTER_RESET);
    send_item(CMD_LOOKUP, MASTER_RESET);
    send_item(CMD_LOOKUP, '1);
    send_item(CMD_ADD, '1);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_REMOVE, '0);
    for (int k = 0; k < 14; k++) send_item(CMD_ADD, {8'(k + 1), 32'hA5A5_0000 + 32'(k)});
    send_item(CMD_ADD, 40'h12_3456_789A);
    send_item(CMD_LOOKUP, {8'd14, 32'hA5A5_000D});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin master = '0;           add_w = 45; rem_w = 15; tx_idle = 1; rx_idle = 1; end
        1: begin master = '1;           add_w = 30; rem_w = 25; tx_idle = 0; rx_idle = 1; end
        2: begin master = rand_id();    add_w = 40; rem_w = 20; tx_idle = 0; rx_idle = 0; end
        3: begin master = MASTER_RESET; add_w = 20; rem_w = 40; tx_idle = 1; rx_idle = 0; end
        4: begin master = rand_id();    add_w = 30; rem_w = 25; tx_idle = 1; rx_idle = 1; end
        default: begin
          master = rand_id(); add_w = 45; rem_w = 15; tx_idle = 0; rx_idle = 0;
        end
      endcase
      write_master(master);
      // long receiver hold while the sender keeps pushing
      if (p == 2) rx_hold = HOLD_CYCLES;

      // small ID pool so adds, lookups and removes keep hitting each other
      id_pool[0] = master;
      id_pool[1] = '0;
      id_pool[2] = '1;
      for (int k = 3; k < POOL_SIZE; k++) id_pool[k] = rand_id();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r  = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? rand_id() : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 3)                  cmd = CMD_UNUSED;
        else if (r < 3 + add_w)     cmd = CMD_ADD;
        else if (r < 3 + add_w + rem_w) cmd = CMD_REMOVE;
        else                        cmd = CMD_LOOKUP;
        send_item(cmd, id);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdicts_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
